FILE: rtl/crc32_word_msb_first_top_macros.svh
// Assertion macros for the CRC-32 word folder.
// Depends on nothing; included by the top level.
`ifndef CRC32_WORD_MSB_FIRST_TOP_MACROS_SVH
`define CRC32_WORD_MSB_FIRST_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRCW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crcw assertion failed");

// Next-cycle implication, disabled during reset.
`define CRCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crcw assertion failed");

`endif

FILE: rtl/crcw_pkg.sv
// Package for the CRC-32 word folder: widths, beat types, byte masking
// and the unrolled MSB-first fold. Depends on nothing.
`timescale 1ns / 1ps

package crcw_pkg;

  localparam int unsigned CRC_W   = 32;
  localparam int unsigned COUNT_W = 3;

  localparam logic [CRC_W-1:0] CRC_POLY     = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] SEED_RESET   = 32'h0000_0000;
  localparam logic [CRC_W-1:0] REM_RESET    = 32'hFFFF_FFFF;

  localparam logic [COUNT_W-1:0] COUNT_NONE  = 3'd0;
  localparam logic [COUNT_W-1:0] COUNT_ONE   = 3'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO   = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;

  typedef struct packed {
    logic [CRC_W-1:0] word;
    logic             fold_en;
    logic             start;
  } beat_t;

  // Keep the valid low bytes, zero the rest; a count of zero or above three keeps the whole word.
  function automatic logic [CRC_W-1:0] keep_mask(input logic [COUNT_W-1:0] count);
    logic [CRC_W-1:0] m;
    case (count)
      COUNT_ONE:   m = 32'h0000_00FF;
      COUNT_TWO:   m = 32'h0000_FFFF;
      COUNT_THREE: m = 32'h00FF_FFFF;
      default:     m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Fold of each single set bit; evaluated at elaboration only.
  function automatic logic [CRC_W-1:0][CRC_W-1:0] fold_columns();
    logic [CRC_W-1:0][CRC_W-1:0] cols;
    logic [CRC_W-1:0]            r;
    for (int i = 0; i < CRC_W; i++) begin
      r = CRC_W'(1) << i;
      for (int k = 0; k < CRC_W; k++) begin
        if (r[CRC_W-1]) begin
          r = (r << 1) ^ CRC_POLY;
        end else begin
          r = r << 1;
        end
      end
      cols[i] = r;
    end
    return cols;
  endfunction

  localparam logic [CRC_W-1:0][CRC_W-1:0] FOLD_COLS = fold_columns();

  // One 32-bit fold as a flat XOR network over the columns.
  function automatic logic [CRC_W-1:0] fold_word(input logic [CRC_W-1:0] x);
    logic [CRC_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < CRC_W; i++) begin
      acc = acc ^ (FOLD_COLS[i] & {CRC_W{x[i]}});
    end
    return acc;
  endfunction

endpackage

FILE: rtl/crc32_word_msb_first_top.sv
// Top level of the CRC-32 word folder (poly 04C11DB7, MSB first).
// Depends on crcw_pkg, crcw_in_stage, crcw_fold_stage and the macro header.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_stall  | data_word, byte_count, start_flag, last_flag
//   out     | out_valid / out_stall| crc_value
//   cfg     | cfg_valid / cfg_ready| cfg_data (seed)
//
// One word per cycle while the output is not stalled. The XOR network sits between the input register and the
// result register. out_valid rises once the input register hands its beat on to the result register,
// which a stalled output can hold back.
// Reset (rst, synchronous) empties both stages, loads the remainder with all
// ones and clears the seed. A stalled output holds its beat; the input stage
// keeps taking beats until both stages are full.
`timescale 1ns / 1ps
`include "crc32_word_msb_first_top_macros.svh"

module crc32_word_msb_first_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [crcw_pkg::CRC_W-1:0]    data_word,
  input  logic [crcw_pkg::COUNT_W-1:0]  byte_count,
  input  logic                          start_flag,
  input  logic                          last_flag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [crcw_pkg::CRC_W-1:0]    crc_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crcw_pkg::CRC_W-1:0]    cfg_data
);

  logic [crcw_pkg::CRC_W-1:0] seed_value;
  logic            s1_valid;
  logic            s1_advance;
  logic            in_load;
  logic            out_drain;
  logic            last_seen;
  crcw_pkg::beat_t s1_beat;

  assign cfg_ready  = 1'b1;
  assign out_drain  = out_valid && !out_stall;
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_load    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= crcw_pkg::SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seed_value <= cfg_data;
    end
  end

  // Track the end-of-message mark of the last beat taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seen <= 1'b0;
    end else if (in_load) begin
      last_seen <= last_flag;
    end
  end

  crcw_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .load       (in_load),
    .advance    (s1_advance),
    .data_word  (data_word),
    .byte_count (byte_count),
    .start_flag (start_flag),
    .valid      (s1_valid),
    .beat       (s1_beat)
  );

  crcw_fold_stage u_fold (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_advance),
    .drain     (out_drain),
    .beat      (s1_beat),
    .seed      (seed_value),
    .valid     (out_valid),
    .crc_value (crc_value)
  );

  `CRCW_ASSERT_NOW(a_stall_needs_full, clk, rst, in_stall, s1_valid && out_valid && out_stall)
  `CRCW_ASSERT_NEXT(a_load_fills_input, clk, rst, in_load, s1_valid)
  `CRCW_ASSERT_NEXT(a_drain_empties, clk, rst, out_drain && !s1_valid, !out_valid)
  `CRCW_ASSERT_NEXT(a_advance_gives_result, clk, rst, s1_advance, out_valid)
  `CRCW_ASSERT_NEXT(a_last_tracks, clk, rst, in_load, last_seen == $past(last_flag))

endmodule

FILE: rtl/crcw_in_stage.sv
// Input register of the CRC-32 word folder: masks the word to its valid
// bytes and holds the beat. Depends on crcw_pkg.
`timescale 1ns / 1ps

module crcw_in_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic                           advance,
  input  logic [crcw_pkg::CRC_W-1:0]     data_word,
  input  logic [crcw_pkg::COUNT_W-1:0]   byte_count,
  input  logic                           start_flag,
  output logic                           valid,
  output crcw_pkg::beat_t                beat
);

  crcw_pkg::beat_t beat_next;

  always_comb begin
    beat_next.word    = data_word & crcw_pkg::keep_mask(byte_count);
    beat_next.fold_en = (byte_count != crcw_pkg::COUNT_NONE);
    beat_next.start   = start_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= beat_next;
    end
  end

endmodule

FILE: rtl/crcw_fold_stage.sv
// Fold stage of the CRC-32 word folder: running remainder, XOR network
// and result register. Depends on crcw_pkg.
`timescale 1ns / 1ps

module crcw_fold_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        drain,
  input  crcw_pkg::beat_t             beat,
  input  logic [crcw_pkg::CRC_W-1:0]  seed,
  output logic                        valid,
  output logic [crcw_pkg::CRC_W-1:0]  crc_value
);

  logic [crcw_pkg::CRC_W-1:0] remainder;
  logic [crcw_pkg::CRC_W-1:0] remainder_next;
  logic [crcw_pkg::CRC_W-1:0] rem_base;

  always_comb begin
    rem_base = beat.start ? ~seed : remainder;
    if (beat.fold_en) begin
      remainder_next = crcw_pkg::fold_word(rem_base ^ beat.word);
    end else begin
      remainder_next = rem_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= crcw_pkg::REM_RESET;
      valid     <= 1'b0;
    end else if (advance) begin
      remainder <= remainder_next;
      valid     <= 1'b1;
    end else if (drain) begin
      valid     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      crc_value <= ~remainder_next;
    end
  end

endmodule

FILE: sim/tb_crc32_word_msb_first_top.sv
// Testbench for crc32_word_msb_first_top: a directed table, then random message streams.
// Checks each crc_value against a behavioral CRC-32 fold predictor or a known value; depends on crcw_pkg.
`timescale 1ns / 1ps

module tb_crc32_word_msb_first_top;

  localparam int unsigned CRC_W   = crcw_pkg::CRC_W;
  localparam int unsigned COUNT_W = crcw_pkg::COUNT_W;

  localparam int STUCK_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 215;
  localparam int LONG_HOLD = 80;
  localparam int DIR_N = 17;

  typedef struct packed {
    logic [CRC_W-1:0]   word;
    logic [COUNT_W-1:0] count;
    logic               start;
    logic               last;
    logic               known;
    logic [CRC_W-1:0]   crc;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{32'h0000_0000, crcw_pkg::COUNT_NONE,  1'b0, 1'b0, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, crcw_pkg::COUNT_NONE,  1'b1, 1'b0, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 3'd4,                  1'b1, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, crcw_pkg::COUNT_ONE,   1'b0, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, crcw_pkg::COUNT_TWO,   1'b0, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, crcw_pkg::COUNT_THREE, 1'b0, 1'b0, 1'b0, 32'h0},
    '{32'hA5A5_A5A5, 3'd5,                  1'b0, 1'b0, 1'b0, 32'h0},
    '{32'h5A5A_5A5A, 3'd6,                  1'b0, 1'b0, 1'b0, 32'h0},
    '{32'h1234_5678, 3'd7,                  1'b0, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0000, 3'd4,                  1'b1, 1'b1, 1'b0, 32'h0},
    '{32'h8000_0000, 3'd4,                  1'b1, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 3'd4,                  1'b0, 1'b1, 1'b0, 32'h0},
    '{32'hDEAD_BEEF, crcw_pkg::COUNT_NONE,  1'b1, 1'b0, 1'b1, 32'h0000_0000},
    '{32'h0000_0001, crcw_pkg::COUNT_ONE,   1'b1, 1'b1, 1'b0, 32'h0},
    '{32'hFFFF_FF00, crcw_pkg::COUNT_THREE, 1'b0, 1'b0, 1'b0, 32'h0},
    '{32'h0000_FF00, crcw_pkg::COUNT_ONE,   1'b0, 1'b0, 1'b0, 32'h0},
    '{32'h1357_9BDF, 3'd4,                  1'b0, 1'b1, 1'b0, 32'h0}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [CRC_W-1:0]   data_word;
  logic [COUNT_W-1:0] byte_count;
  logic               start_flag;
  logic               last_flag;
  logic               out_valid;
  logic               out_stall;
  logic [CRC_W-1:0]   crc_value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CRC_W-1:0]   cfg_data;

  logic [CRC_W-1:0] crc_expect_q [$];
  logic [CRC_W-1:0] model_rem;
  logic [CRC_W-1:0] model_seed;
  int               err_cnt;
  int               stuck_cycles;
  bit               idle_off;
  bit               long_hold_req;
  bit               long_hold_done;
  int               long_hold_cnt;

  crc32_word_msb_first_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .byte_count (byte_count),
    .start_flag (start_flag),
    .last_flag  (last_flag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .crc_value  (crc_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] rem,
                                               input logic [CRC_W-1:0] word);
    logic [CRC_W-1:0] r;
    r = rem ^ word;
    for (int k = 0; k < CRC_W; k++) begin
      if (r[CRC_W-1]) begin
        r = (r << 1) ^ crcw_pkg::CRC_POLY;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] crc_advance(input logic [CRC_W-1:0] word,
                                                  input logic [COUNT_W-1:0] count,
                                                  input logic start);
    logic [CRC_W-1:0] kept;
    if (start) begin
      model_rem = ~model_seed;
    end
    case (count)
      crcw_pkg::COUNT_ONE:   kept = word & 32'h0000_00FF;
      crcw_pkg::COUNT_TWO:   kept = word & 32'h0000_FFFF;
      crcw_pkg::COUNT_THREE: kept = word & 32'h00FF_FFFF;
      default:               kept = word;
    endcase
    if (count != crcw_pkg::COUNT_NONE) begin
      model_rem = crc_fold(model_rem, kept);
    end
    return ~model_rem;
  endfunction

  task automatic send_beat(input logic [CRC_W-1:0] word, input logic [COUNT_W-1:0] count,
                           input logic start, input logic last,
                           input logic known, input logic [CRC_W-1:0] crc);
    logic [CRC_W-1:0] predicted;
    if (!idle_off) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    data_word  <= word;
    byte_count <= count;
    start_flag <= start;
    last_flag  <= last;
    do @(posedge clk); while (in_stall);
    predicted = crc_advance(word, count, start);
    crc_expect_q.push_back(known ? crc : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (crc_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [CRC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    model_seed = value;
  endtask

  task automatic run_messages(input int n_items);
    int               sent;
    int               len;
    logic [COUNT_W-1:0] cnt;
    logic             first_start;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_beat($urandom, COUNT_W'($urandom_range(7)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end else begin
        len = $urandom_range(8, 1);
        first_start = ($urandom_range(99) < 92);
        for (int i = 0; i < len; i++) begin
          cnt = (i == len - 1) ? COUNT_W'($urandom_range(4, 1)) : 3'd4;
          send_beat($urandom, cnt, (i == 0) ? first_start : 1'b0, i == len - 1, 1'b0, '0);
        end
        sent += len;
      end
    end
  endtask

  // Receiver: check the beat, then choose next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (crc_expect_q.size() == 0) begin
        $error("unexpected beat: crc_value actual %08h", crc_value);
        err_cnt++;
      end else begin
        if (crc_value !== crc_expect_q[0]) begin
          $error("crc_value mismatch: expected %08h actual %08h", crc_expect_q[0], crc_value);
          err_cnt++;
        end
        void'(crc_expect_q.pop_front());
      end
    end
    if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      long_hold_cnt  = LONG_HOLD;
    end
    if (long_hold_cnt != 0) begin
      long_hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !idle_off && ($urandom_range(99) < 22);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [CRC_W-1:0] phase_seed [PHASES];
    err_cnt        = 0;
    stuck_cycles   = 0;
    idle_off       = 1'b0;
    long_hold_req  = 1'b0;
    long_hold_done = 1'b0;
    long_hold_cnt  = 0;
    model_rem      = crcw_pkg::REM_RESET;
    model_seed     = crcw_pkg::SEED_RESET;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    data_word  <= '0;
    byte_count <= crcw_pkg::COUNT_NONE;
    start_flag <= 1'b0;
    last_flag  <= 1'b0;
    out_stall  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    phase_seed[0] = 32'hFFFF_FFFF;
    phase_seed[1] = crcw_pkg::SEED_RESET;
    phase_seed[2] = $urandom;
    phase_seed[3] = $urandom;
    phase_seed[4] = 32'h8000_0001;
    phase_seed[5] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      send_beat(DIR_ROWS[i].word, DIR_ROWS[i].count, DIR_ROWS[i].start, DIR_ROWS[i].last,
                DIR_ROWS[i].known, DIR_ROWS[i].crc);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      idle_off = (p == 2);
      write_seed(phase_seed[p]);
      send_beat(32'h0, crcw_pkg::COUNT_NONE, 1'b1, 1'b0, 1'b1, phase_seed[p]);
      long_hold_req = (p == 3);
      run_messages(PHASE_ITEMS);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/crcw_pkg.sv
rtl/crcw_in_stage.sv
rtl/crcw_fold_stage.sv
rtl/crc32_word_msb_first_top.sv
sim/tb_crc32_word_msb_first_top.sv
